@@ rtl/core/hcd_pkg.sv @@
// shared types and constants of the chunked transfer decoder
// depends on nothing; imported by every module of the block
`default_nettype none

package hcd_pkg;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // result status codes
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic [1:0] status;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] digit;
  } cls_item_t;

endpackage

`default_nettype wire

@@ rtl/core/http_chunked_decoder.sv @@
// top level of the http chunked transfer decoder
// depends on hcd_pkg, hcd_classify, hcd_queue and hcd_exec
`default_nettype none

// Streams one byte of chunked-encoded input per request and returns decoded
// chunk data one byte per result, with chunk_end flagged on the last byte of
// each chunk. A request with end_of_stream set returns a clean-end status, or
// a truncated status if a header or chunk is unfinished. A bad size header
// returns a malformed status; after either error the block stays silent until
// reset. Header bytes, stray CR/LF between chunks and zero-size chunks produce
// no result. Throughput is one byte per cycle sustained while out_ready_i stays
// high: the back stage does one hex shift-add or one chunk count decrement per
// cycle. A taken request is first written into the two-entry queue; the back
// stage then pops it, updates state and loads the output register, and the
// input keeps flowing while a result waits for out_ready_i until the queue
// fills. SIZE_BITS sets the width of the chunk size counter; a header whose
// value does not fit in it is malformed.

module http_chunked_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hcd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hcd_pkg::out_item_t out_item_o
);
  import hcd_pkg::*;

  cls_item_t cls;        // classified request from the front
  cls_item_t q_item;     // head of the queue
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  // front: byte classes are decided before the request is queued
  hcd_classify u_classify (
    .item_i (in_item_i),
    .cls_o  (cls)
  );

  // queue decouples input acceptance from output backpressure
  hcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_item)
  );

  assign in_ready_o = !q_full;

  // back: parser state and output register
  hcd_exec #(
    .SIZE_BITS (SIZE_BITS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/hcd_classify.sv @@
// front stage: decodes each incoming byte into cr/lf/hex classes
// depends on hcd_pkg
`default_nettype none

module hcd_classify (
  input  hcd_pkg::in_item_t  item_i,
  output hcd_pkg::cls_item_t cls_o
);
  import hcd_pkg::*;

  logic [7:0] c;

  assign c = item_i.in_byte;

  always_comb begin
    cls_o.data   = c;
    cls_o.eos    = item_i.end_of_stream;
    cls_o.is_cr  = (c == ChCr);
    cls_o.is_lf  = (c == ChLf);
    cls_o.is_hex = 1'b1;
    cls_o.digit  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls_o.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      cls_o.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      cls_o.digit = 4'(c - 8'h37);
    end else begin
      cls_o.is_hex = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcd_queue.sv @@
// two-entry queue between classify front and decode back
// depends on hcd_pkg
`default_nettype none

module hcd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hcd_pkg::cls_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output hcd_pkg::cls_item_t pop_data_o
);
  import hcd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cls_item_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == (PtrW+1)'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcd_exec.sv @@
// back stage: header parse, chunk count and registered result
// depends on hcd_pkg
`default_nettype none

module hcd_exec #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hcd_pkg::cls_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcd_pkg::out_item_t  out_item_o
);
  import hcd_pkg::*;

  logic [SIZE_BITS-1:0] chunk_rem_q, chunk_rem_d;
  logic [SIZE_BITS-1:0] hdr_val_q, hdr_val_d;
  logic                 in_hdr_q, in_hdr_d;
  logic [1:0]           hdr_len_q, hdr_len_d;
  logic                 prev_cr_q, prev_cr_d;
  logic                 hdr_bad_q, hdr_bad_d;
  logic                 failed_q, failed_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  logic                 emit;
  out_item_t            res;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    chunk_rem_d = chunk_rem_q;
    hdr_val_d   = hdr_val_q;
    in_hdr_d    = in_hdr_q;
    hdr_len_d   = hdr_len_q;
    prev_cr_d   = prev_cr_q;
    hdr_bad_d   = hdr_bad_q;
    failed_d    = failed_q;
    emit        = 1'b0;
    res         = '{out_byte: 8'd0, chunk_end: 1'b0, status: ST_DATA};

    if (pop_o && !failed_q) begin
      if (item_i.eos) begin
        emit = 1'b1;
        if (chunk_rem_q != '0 || in_hdr_q) begin
          failed_d   = 1'b1;
          res.status = ST_TRUNCATED;
        end else begin
          res.status = ST_END;
        end
      end else if (chunk_rem_q != '0) begin
        emit          = 1'b1;
        chunk_rem_d   = chunk_rem_q - 1'b1;
        res.out_byte  = item_i.data;
        res.chunk_end = (chunk_rem_q == SIZE_BITS'(1));
      end else if (!in_hdr_q && (item_i.is_cr || item_i.is_lf)) begin
        // stray line breaks between chunks
      end else if (item_i.is_lf) begin
        hdr_val_d = '0;
        in_hdr_d  = 1'b0;
        hdr_len_d = 2'd0;
        prev_cr_d = 1'b0;
        hdr_bad_d = 1'b0;
        if (hdr_len_q < 2'd2 || !prev_cr_q || hdr_bad_q) begin
          emit       = 1'b1;
          failed_d   = 1'b1;
          res.status = ST_MALFORMED;
        end else begin
          chunk_rem_d = hdr_val_q;
        end
      end else begin
        in_hdr_d = 1'b1;
        if (hdr_len_q < 2'd2) begin
          hdr_len_d = hdr_len_q + 1'b1;
        end
        if (prev_cr_q) begin
          hdr_bad_d = 1'b1;
        end
        if (item_i.is_cr) begin
          prev_cr_d = 1'b1;
        end else begin
          prev_cr_d = 1'b0;
          if (!item_i.is_hex) begin
            hdr_bad_d = 1'b1;
          end else if (!hdr_bad_d) begin
            // overflow when the top digit is already occupied
            if (hdr_val_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              hdr_bad_d = 1'b1;
            end else begin
              hdr_val_d = {hdr_val_q[SIZE_BITS-5:0], item_i.digit};
            end
          end
        end
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_rem_q <= '0;
      hdr_val_q   <= '0;
      in_hdr_q    <= 1'b0;
      hdr_len_q   <= 2'd0;
      prev_cr_q   <= 1'b0;
      hdr_bad_q   <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      chunk_rem_q <= chunk_rem_d;
      hdr_val_q   <= hdr_val_d;
      in_hdr_q    <= in_hdr_d;
      hdr_len_q   <= hdr_len_d;
      prev_cr_q   <= prev_cr_d;
      hdr_bad_q   <= hdr_bad_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/hcd_checker.sv @@
// port-level checks for the chunked transfer decoder, bound to the top level
// depends on hcd_pkg and http_chunked_decoder
`default_nettype none

module hcd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input hcd_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hcd_pkg::out_item_t out_item_o
);
  import hcd_pkg::*;

  logic err_seen_q;
  logic req_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      req_seen_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i &&
          (out_item_o.status == ST_MALFORMED || out_item_o.status == ST_TRUNCATED)) begin
        err_seen_q <= 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        req_seen_q <= 1'b1;
      end
    end
  end

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // errors are sticky: nothing follows a delivered error
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !out_valid_o)
    else $error("result after error");

  // non-data results carry no byte and no chunk mark
  a_nondata_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_DATA |->
      out_item_o.out_byte == 8'd0 && !out_item_o.chunk_end)
    else $error("non-data result with payload");

  // no result before any request was taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> req_seen_q)
    else $error("result without request");

  // input never stalls before any request was taken
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> req_seen_q)
    else $error("input stalled with nothing taken");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (.*);

`default_nettype wire

@@ tb/tb_http_chunked_decoder.sv @@
// self-checking testbench for http_chunked_decoder
// streams directed and random chunked-encoded bytes and checks every result
// against an in-bench decoder model; depends on hcd_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_http_chunked_decoder;
  import hcd_pkg::*;

  localparam int unsigned SizeBits = 32;
  localparam logic [63:0] SizeMask = ~64'd0 >> (64 - SizeBits);

  // ways to break the stream in the closing error test
  typedef enum int {
    BadDigit, NoCr, OneChar, Overflow, InnerCr, Prefix, CutHeader, CutChunk
  } fault_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // decoder model state
  logic [63:0] chunk_left;
  logic [63:0] hdr_value;
  logic        hdr_open;
  logic [1:0]  hdr_len;
  logic        hdr_cr;
  logic        hdr_bad;
  logic        dec_failed;

  out_item_t decoded_q[$];
  int        err_cnt;
  int        sent_cnt;
  bit        src_idle_on;
  bit        sink_stall_on;

  http_chunked_decoder #(
    .SIZE_BITS(SizeBits)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // hex digit value of a character, valid flag in bit 4
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic void clear_hdr();
    hdr_value = '0;
    hdr_open  = 1'b0;
    hdr_len   = '0;
    hdr_cr    = 1'b0;
    hdr_bad   = 1'b0;
  endfunction

  // one decoder step; returns 1 when the request yields a result
  function automatic bit decode_byte(input in_item_t req, output out_item_t res);
    logic [7:0]  c;
    logic [4:0]  hv;
    logic [63:0] v;
    c   = req.in_byte;
    res = '0;
    // errors are sticky until reset
    if (dec_failed) return 1'b0;
    if (req.end_of_stream) begin
      if (chunk_left != 0 || hdr_open) begin
        dec_failed = 1'b1;
        res.status = ST_TRUNCATED;
      end else begin
        res.status = ST_END;
      end
      return 1'b1;
    end
    // inside a chunk every byte is data, cr and lf included
    if (chunk_left != 0) begin
      chunk_left    = (chunk_left - 1) & SizeMask;
      res.out_byte  = c;
      res.chunk_end = (chunk_left == 0);
      res.status    = ST_DATA;
      return 1'b1;
    end
    // stray line breaks between chunks
    if (!hdr_open && (c == ChCr || c == ChLf)) return 1'b0;
    hdr_open = 1'b1;
    if (c == ChLf) begin
      v = hdr_value;
      if (hdr_len < 2 || !hdr_cr || hdr_bad) begin
        clear_hdr();
        dec_failed = 1'b1;
        res.status = ST_MALFORMED;
        return 1'b1;
      end
      clear_hdr();
      chunk_left = v & SizeMask;
      return 1'b0;
    end
    if (hdr_len < 2) hdr_len++;
    // anything after a cr other than lf spoils the header
    if (hdr_cr) hdr_bad = 1'b1;
    if (c == ChCr) begin
      hdr_cr = 1'b1;
    end else begin
      hv     = hex_value(c);
      hdr_cr = 1'b0;
      if (!hv[4]) begin
        hdr_bad = 1'b1;
      end else if (!hdr_bad) begin
        if ((hdr_value >> (SizeBits - 4)) != 0) hdr_bad = 1'b1;
        else hdr_value = ((hdr_value << 4) + 64'(hv[3:0])) & SizeMask;
      end
    end
    return 1'b0;
  endfunction

  // send one request; valid stays up after acceptance until the next call
  task automatic send_req(input logic [7:0] data, input logic eos);
    out_item_t res;
    in_item_t  req;
    req.in_byte       = data;
    req.end_of_stream = eos;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk); while (!in_ready_o);
    sent_cnt++;
    if (decode_byte(req, res)) decoded_q.insert(decoded_q.size(), res);
  endtask

  task automatic send_crlf();
    send_req(ChCr, 1'b0);
    send_req(ChLf, 1'b0);
  endtask

  // size line with optional leading zeros and random letter case
  task automatic send_header(input longint unsigned len, input int zeros);
    int nd;
    nd = 1;
    while (nd < 16 && (len >> (4 * nd)) != 0) nd++;
    repeat (zeros) send_req(8'h30, 1'b0);
    for (int i = nd - 1; i >= 0; i--)
      send_req(hex_char(len[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
    send_crlf();
  endtask

  // well-formed chunk with random data and trailing line break
  task automatic send_chunk(input int len, input int zeros);
    send_header(64'(len), zeros);
    repeat (len) send_req(8'($urandom_range(0, 255)), 1'b0);
    send_crlf();
  endtask

  // stop sending until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // output side: random stall bursts while enabled
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready_i <= 1'b1;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d byte=%02h",
                                  out_item_o.status, out_item_o.out_byte));
      end else begin
        want = decoded_q.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_item_o.status, want.status));
        if (out_item_o.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte got %02h want %02h",
                                    out_item_o.out_byte, want.out_byte));
        if (out_item_o.chunk_end !== want.chunk_end)
          report_mismatch($sformatf("chunk_end got %0b want %0b",
                                    out_item_o.chunk_end, want.chunk_end));
      end
    end
  end

  // end markers on a clean state, stray line breaks, repeated end
  task automatic test_end_marker();
    send_req(8'h00, 1'b1);
    send_req(8'hFF, 1'b1);
    send_req(ChCr, 1'b0);
    send_req(ChLf, 1'b0);
    send_req(8'h5A, 1'b1);
  endtask

  // small chunks: extreme data, zero size, leading zeros, cr as data
  task automatic test_small_chunks();
    send_req(8'h31, 1'b0);
    send_crlf();
    send_req(8'hFF, 1'b0);
    send_crlf();
    send_header(64'd0, 0);
    send_header(64'd3, 12);
    send_req(8'h00, 1'b0);
    send_req(ChCr, 1'b0);
    send_req(8'h80, 1'b0);
    send_req(8'h00, 1'b1);
  endtask

  // random well-formed stream with stray breaks, empty chunks and end markers
  task automatic test_random_stream(input int target);
    int len;
    while (sent_cnt < target) begin
      repeat ($urandom_range(0, 2)) send_req($urandom_range(0, 1) ? ChCr : ChLf, 1'b0);
      if ($urandom_range(0, 7) == 0) send_req(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 255);
      else len = $urandom_range(0, 16);
      send_chunk(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12)
                                                   : 0);
    end
  endtask

  // one way to break the stream, then check nothing more comes out
  task automatic test_sticky_error();
    fault_e     fault;
    logic [7:0] c;
    fault = fault_e'($urandom_range(0, 7));
    case (fault)
      BadDigit: begin
        do c = 8'($urandom_range(0, 255));
        while (hex_value(c) != 0 || c == ChCr || c == ChLf);
        send_req(8'h31, 1'b0);
        send_req(c, 1'b0);
        send_crlf();
      end
      NoCr: begin
        send_req(8'h31, 1'b0);
        send_req(8'h32, 1'b0);
        send_req(ChLf, 1'b0);
      end
      OneChar: begin
        send_req(8'h37, 1'b0);
        send_req(ChLf, 1'b0);
      end
      Overflow: begin
        send_header(64'h1_0000_0000, 0);
      end
      InnerCr: begin
        send_req(8'h31, 1'b0);
        send_req(ChCr, 1'b0);
        send_req(8'h32, 1'b0);
        send_crlf();
      end
      Prefix: begin
        // space, sign or 0x ahead of the digits
        case ($urandom_range(0, 3))
          0: send_req(8'h20, 1'b0);
          1: send_req(8'h2B, 1'b0);
          2: send_req(8'h2D, 1'b0);
          default: begin
            send_req(8'h30, 1'b0);
            send_req(8'h78, 1'b0);
          end
        endcase
        send_req(8'h35, 1'b0);
        send_crlf();
      end
      CutHeader: begin
        send_req(8'h31, 1'b0);
        send_req(8'h32, 1'b0);
        send_req(8'h00, 1'b1);
      end
      default: begin
        // largest size that fits, cut short
        send_header(SizeMask, 0);
        repeat ($urandom_range(1, 8)) send_req(8'($urandom_range(0, 255)), 1'b0);
        send_req(8'h00, 1'b1);
      end
    endcase
    // all further requests must stay silent
    send_req(8'h00, 1'b1);
    send_chunk(2, 0);
    repeat (16) send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
  endtask

  initial begin
    err_cnt       = 0;
    sent_cnt      = 0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    chunk_left    = '0;
    dec_failed    = 1'b0;
    clear_hdr();

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_end_marker();
    test_small_chunks();
    test_random_stream(650);
    drain_results();
    test_random_stream(1250);
    // last part runs at full rate on both sides
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    test_random_stream(1420);
    test_sticky_error();

    @(negedge clk);
    in_valid_i <= 1'b0;
    for (int i = 0; i < 2000 && decoded_q.size() != 0; i++) @(posedge clk);
    // catch any late extra result
    repeat (10) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hcd_pkg.sv
rtl/core/hcd_classify.sv
rtl/core/hcd_queue.sv
rtl/core/hcd_exec.sv
rtl/core/http_chunked_decoder.sv
rtl/core/hcd_checker.sv
tb/tb_http_chunked_decoder.sv
